// ===== rtl/core/jdnc_pkg.sv =====
// Shared constants, widths and helpers for the Julian day number converter.
// Used by jdnc_core and julian_day_number_conversion_top; no dependencies.

package jdnc_pkg;

  localparam int JDN_W  = 23;
  localparam int YEAR_W = 15;
  localparam int MON_W  = 4;
  localparam int DAYI_W = 6;
  localparam int DAYO_W = 5;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam int REG_START = 0;
  localparam logic [PADDR_W-1:0] ADDR_START = PADDR_W'(4 * REG_START);

  localparam logic [JDN_W-1:0] START_RESET = 23'd2299161;

  localparam logic CMD_TO_DAY  = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  localparam logic [17:0] CYC_DAYS = 18'd146097;
  localparam logic [10:0] YR_DAYS  = 11'd1461;

  // Reciprocals: floor(x * K >> S) == floor(x / D) for x < 2**(S - clog2(D))
  localparam int S_HUN = 22;
  localparam logic [15:0] K_HUN = 16'(((64'd1 << S_HUN) + 64'd99) / 64'd100);
  localparam int S_CYC = 44;
  localparam logic [26:0] K_CYC = 27'(((64'd1 << S_CYC) + 64'd146096) / 64'd146097);
  localparam int S_YR = 37;
  localparam logic [26:0] K_YR = 27'(((64'd1 << S_YR) + 64'd1460) / 64'd1461);
  localparam int S_MO = 19;
  localparam logic [11:0] K_MO = 12'(((64'd1 << S_MO) + 64'd152) / 64'd153);

  // Days before month m of a March-based year, (153 * m + 2) / 5
  function automatic logic [8:0] mon_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/julian_day_number_conversion_top.sv =====
// Julian day number converter top level: cutover register and APB port.
// Depends on jdnc_pkg and jdnc_core.

// Converts a calendar date (cmd 0) to a Julian day number, or a Julian day
// number (cmd 1) back to year, month and day, switching between the Julian
// and Gregorian calendars at the day number held in gregorian_start_day
// (APB byte address 0, reset 2299161). The block takes one item every clock
// cycle while item_stall is low, and each result passes through the registered
// stages of the conversion pipeline. A stalled result holds the last stage and
// every full stage behind it; empty stages further back keep filling. Write the
// register only while no item is in flight.

module julian_day_number_conversion_top
  import jdnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     cmd,
  input  logic signed [YEAR_W-1:0] year_in,
  input  logic [MON_W-1:0]         month_in,
  input  logic [DAYI_W-1:0]        day_in,
  input  logic [JDN_W-1:0]         day_number_in,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [JDN_W-1:0]         day_number_out,
  output logic signed [YEAR_W-1:0] year_out,
  output logic [MON_W-1:0]         month_out,
  output logic [DAYO_W-1:0]        day_out,
  output logic                     bad_date
);

  logic [JDN_W-1:0] gregorian_start_day;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_START);
  assign prdata    = (paddr == ADDR_START) ? PDATA_W'(gregorian_start_day) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gregorian_start_day <= START_RESET;
    end else if (cfg_write) begin
      gregorian_start_day <= pwdata[JDN_W-1:0];
    end
  end

  jdnc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (gregorian_start_day),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cmd            (cmd),
    .year_in        (year_in),
    .month_in       (month_in),
    .day_in         (day_in),
    .day_number_in  (day_number_in),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .day_number_out (day_number_out),
    .year_out       (year_out),
    .month_out      (month_out),
    .day_out        (day_out),
    .bad_date       (bad_date)
  );

endmodule

// ===== rtl/core/jdnc_core.sv =====
// Seven-stage conversion pipeline, date to day number and day number to date.
// Depends on jdnc_pkg for widths, reciprocal constants and the month table.

module jdnc_core
  import jdnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [JDN_W-1:0]         start,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     cmd,
  input  logic signed [YEAR_W-1:0] year_in,
  input  logic [MON_W-1:0]         month_in,
  input  logic [DAYI_W-1:0]        day_in,
  input  logic [JDN_W-1:0]         day_number_in,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [JDN_W-1:0]         day_number_out,
  output logic signed [YEAR_W-1:0] year_out,
  output logic [MON_W-1:0]         month_out,
  output logic [DAYO_W-1:0]        day_out,
  output logic                     bad_date
);

  logic [7:1] v;
  logic [7:1] adv;

  always_comb begin
    adv[7] = !v[7] || !result_stall;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign item_stall   = !adv[1];
  assign result_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= item_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: month shift, year offset, cutover test
  logic              a_flag;
  logic [15:0]       y1;
  logic [3:0]        m0;
  logic [23:0]       ag1;
  logic [23:0]       cj1;

  logic              s1_cmd;
  logic              s1_bad;
  logic              s1_yneg;
  logic signed [15:0] s1_y;
  logic [14:0]       s1_ymag;
  logic [4:0]        s1_day;
  logic [8:0]        s1_t;
  logic              s1_greg;
  logic [23:0]       s1_ag;
  logic [23:0]       s1_cj;

  assign a_flag = month_in <= 4'd2;
  assign y1  = {year_in[YEAR_W-1], year_in} + 16'd4800 - 16'(a_flag);
  assign ag1 = {1'b0, day_number_in} + 24'd32044;
  assign cj1 = {1'b0, day_number_in} + 24'd32082;

  always_comb begin
    case (month_in)
      4'd0:    m0 = 4'd9;
      4'd1:    m0 = 4'd10;
      4'd2:    m0 = 4'd11;
      default: m0 = month_in - 4'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_cmd  <= cmd;
      s1_bad  <= day_in[5] || (month_in > 4'd12);
      s1_yneg <= y1[15];
      s1_y    <= y1;
      s1_ymag <= y1[15] ? 15'(-y1) : y1[14:0];
      s1_day  <= day_in[4:0];
      s1_t    <= mon_offset(m0);
      s1_greg <= day_number_in >= start;
      s1_ag   <= ag1;
      s1_cj   <= cj1;
    end
  end

  // stage 2: century quotient, day base, 400-year cycle quotient
  logic [30:0]        hun_prod;
  logic [52:0]        cyc_prod;
  logic signed [24:0] y_w;
  logic [24:0]        q4;
  logic signed [24:0] q4_w;
  logic signed [24:0] base2;

  logic              s2_cmd;
  logic              s2_bad;
  logic              s2_yneg;
  logic [7:0]        s2_q100;
  logic signed [24:0] s2_base;
  logic              s2_greg;
  logic [23:0]       s2_ag;
  logic [23:0]       s2_cj;
  logic [7:0]        s2_b;

  assign hun_prod = 31'(s1_ymag) * 31'(K_HUN);
  assign cyc_prod = 53'({s1_ag, 2'b11}) * 53'(K_CYC);
  assign y_w      = {{9{s1_y[15]}}, s1_y};
  assign q4       = {12'd0, s1_ymag[14:2]};
  assign q4_w     = s1_yneg ? -q4 : q4;
  assign base2    = y_w * 25'sd365 + q4_w + 25'(s1_day) + 25'(s1_t);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_cmd  <= s1_cmd;
      s2_bad  <= s1_bad;
      s2_yneg <= s1_yneg;
      s2_q100 <= hun_prod[S_HUN+7:S_HUN];
      s2_base <= base2;
      s2_greg <= s1_greg;
      s2_ag   <= s1_ag;
      s2_cj   <= s1_cj;
      s2_b    <= cyc_prod[S_CYC+7:S_CYC];
    end
  end

  // stage 3: Gregorian day number, day within cycle
  logic [24:0]        hun;
  logic [24:0]        four;
  logic signed [24:0] hun_s;
  logic signed [24:0] four_s;
  logic [25:0]        cg_sub;
  logic [23:0]        cg;

  logic              s3_cmd;
  logic              s3_bad;
  logic signed [24:0] s3_base;
  logic signed [24:0] s3_jdg;
  logic [23:0]       s3_c;
  logic [7:0]        s3_b;

  assign hun    = {17'd0, s2_q100};
  assign four   = {19'd0, s2_q100[7:2]};
  assign hun_s  = s2_yneg ? -hun : hun;
  assign four_s = s2_yneg ? -four : four;
  assign cg_sub = 26'(s2_b) * 26'(CYC_DAYS);
  assign cg     = s2_ag - cg_sub[25:2];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cmd  <= s2_cmd;
      s3_bad  <= s2_bad;
      s3_base <= s2_base;
      s3_jdg  <= s2_base - hun_s + four_s - 25'sd32045;
      s3_c    <= s2_greg ? cg : s2_cj;
      s3_b    <= s2_greg ? s2_b : 8'd0;
    end
  end

  // stage 4: calendar pick and clamp, 4-year cycle quotient
  logic               use_jul;
  logic signed [24:0] jd_sel;
  logic [JDN_W-1:0]   jdn4;
  logic [52:0]        yr_prod;

  logic              s4_cmd;
  logic              s4_bad;
  logic [JDN_W-1:0]  s4_jdn;
  logic [23:0]       s4_c;
  logic [7:0]        s4_b;
  logic [14:0]       s4_d;

  assign use_jul = s3_jdg < $signed({2'b00, start});
  assign jd_sel  = use_jul ? s3_base - 25'sd32083 : s3_jdg;
  assign yr_prod = 53'({s3_c, 2'b11}) * 53'(K_YR);

  always_comb begin
    if (s3_bad || jd_sel[24]) begin
      jdn4 = '0;
    end else if (jd_sel[23]) begin
      jdn4 = '1;
    end else begin
      jdn4 = jd_sel[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_cmd <= s3_cmd;
      s4_bad <= s3_bad;
      s4_jdn <= jdn4;
      s4_c   <= s3_c;
      s4_b   <= s3_b;
      s4_d   <= yr_prod[S_YR+14:S_YR];
    end
  end

  // stage 5: day within year
  logic [25:0] yd_sub;
  logic [23:0] e_full;

  logic              s5_cmd;
  logic              s5_bad;
  logic [JDN_W-1:0]  s5_jdn;
  logic [7:0]        s5_b;
  logic [14:0]       s5_d;
  logic [8:0]        s5_e;

  assign yd_sub = 26'(s4_d) * 26'(YR_DAYS);
  assign e_full = s4_c - yd_sub[25:2];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_cmd <= s4_cmd;
      s5_bad <= s4_bad;
      s5_jdn <= s4_jdn;
      s5_b   <= s4_b;
      s5_d   <= s4_d;
      s5_e   <= e_full[8:0];
    end
  end

  // stage 6: March-based month
  logic [10:0] x3;
  logic [22:0] mo_prod;

  logic              s6_cmd;
  logic              s6_bad;
  logic [JDN_W-1:0]  s6_jdn;
  logic [7:0]        s6_b;
  logic [14:0]       s6_d;
  logic [8:0]        s6_e;
  logic [3:0]        s6_m;

  assign x3      = {s5_e, 2'b00} + 11'(s5_e) + 11'd2;
  assign mo_prod = 23'(x3) * 23'(K_MO);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_cmd <= s5_cmd;
      s6_bad <= s5_bad;
      s6_jdn <= s5_jdn;
      s6_b   <= s5_b;
      s6_d   <= s5_d;
      s6_e   <= s5_e;
      s6_m   <= mo_prod[S_MO+3:S_MO];
    end
  end

  // stage 7: final date fields and result register
  logic               wrap;
  logic signed [16:0] yr;
  logic [YEAR_W-1:0]  yr_sat;
  logic [8:0]         dd;

  assign wrap = s6_m >= 4'd10;
  assign yr   = 17'(s6_b) * 17'd100 + 17'(s6_d) + 17'(wrap) - 17'd4800;
  assign dd   = s6_e - mon_offset(s6_m) + 9'd1;

  always_comb begin
    if (yr > 17'sd16383) begin
      yr_sat = 15'h3FFF;
    end else if (yr < -17'sd16384) begin
      yr_sat = 15'h4000;
    end else begin
      yr_sat = yr[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (s6_cmd == CMD_TO_DAY) begin
        day_number_out <= s6_jdn;
        bad_date       <= s6_bad;
        year_out       <= '0;
        month_out      <= '0;
        day_out        <= '0;
      end else begin
        day_number_out <= '0;
        bad_date       <= 1'b0;
        year_out       <= yr_sat;
        month_out      <= wrap ? s6_m - 4'd9 : s6_m + 4'd3;
        day_out        <= dd[4:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_empty_entry: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> !item_stall)
    else $error("entry stage empty but input stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_date) |->
      (day_number_out == '0 && year_out == '0 && month_out == '0 && day_out == '0))
    else $error("bad date result carries nonzero fields");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && month_out != '0) |->
      (month_out <= 4'd12 && day_out != '0 && day_number_out == '0 && !bad_date))
    else $error("date result out of range");

  a_split: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (day_number_out == '0 || month_out == '0))
    else $error("both directions present in one result");
`endif

endmodule

// ===== tb/julian_day_number_conversion_top_test.sv =====
// Testbench for julian_day_number_conversion_top: date <-> Julian day number conversion
// under random valid/stall gaps, with several Gregorian cutover settings written over APB.
// Depends on jdnc_pkg and the julian_day_number_conversion_top RTL.

module julian_day_number_conversion_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jdnc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MAX   = 10;

  typedef struct packed {
    logic                     cmd;
    logic signed [YEAR_W-1:0] year;
    logic [MON_W-1:0]         month;
    logic [DAYI_W-1:0]        mday;
    logic [JDN_W-1:0]         jdn;
  } conv_request_t;

  typedef struct packed {
    logic [JDN_W-1:0]         jdn;
    logic signed [YEAR_W-1:0] year;
    logic [MON_W-1:0]         month;
    logic [DAYO_W-1:0]        mday;
    logic                     bad_date;
  } conv_answer_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = ADDR_START;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic                     cmd = CMD_TO_DAY;
  logic signed [YEAR_W-1:0] year_in = '0;
  logic [MON_W-1:0]         month_in = '0;
  logic [DAYI_W-1:0]        day_in = '0;
  logic [JDN_W-1:0]         day_number_in = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [JDN_W-1:0]         day_number_out;
  logic signed [YEAR_W-1:0] year_out;
  logic [MON_W-1:0]         month_out;
  logic [DAYO_W-1:0]        day_out;
  logic                     bad_date;

  conv_answer_t     answers_due[$];
  logic [JDN_W-1:0] cutover_day = START_RESET;
  bit               no_idle = 1'b0;
  int               stall_left = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  int               results_seen = 0;
  int               dates_sent = 0;
  int               bad_dates_sent = 0;
  int               day_numbers_sent = 0;
  int               settings_used = 0;

  always #4 clk = ~clk;

  julian_day_number_conversion_top dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .year_in       (year_in),
    .month_in      (month_in),
    .day_in        (day_in),
    .day_number_in (day_number_in),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .day_number_out(day_number_out),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .bad_date      (bad_date)
  );

  function automatic conv_answer_t convert_calendar(input conv_request_t rq,
                                                    input logic [JDN_W-1:0] cut);
    conv_answer_t r;
    longint a, b, c, d, e, m, y, base, jd, yr, mo, dy;
    r = '0;
    if (rq.cmd == CMD_TO_DAY) begin
      if (rq.mday > 31 || rq.month > 12) begin
        r.bad_date = 1'b1;
      end else begin
        a = (14 - longint'(rq.month)) / 12;
        y = longint'(rq.year) + 4800 - a;
        m = longint'(rq.month) + 12 * a - 3;
        base = longint'(rq.mday) + (153 * m + 2) / 5 + 365 * y + y / 4;
        jd = base - y / 100 + y / 400 - 32045;
        if (jd < longint'(cut)) jd = base - 32083;
        if (jd < 0) jd = 0;
        if (jd > 8388607) jd = 8388607;
        r.jdn = jd[JDN_W-1:0];
      end
    end else begin
      jd = longint'(rq.jdn);
      if (jd >= longint'(cut)) begin
        a = jd + 32044;
        b = (4 * a + 3) / 146097;
        c = a - (b * 146097) / 4;
      end else begin
        b = 0;
        c = jd + 32082;
      end
      d = (4 * c + 3) / 1461;
      e = c - (1461 * d) / 4;
      m = (5 * e + 2) / 153;
      dy = e - (153 * m + 2) / 5 + 1;
      mo = m + 3 - 12 * (m / 10);
      yr = 100 * b + d - 4800 + m / 10;
      if (yr > 16383) yr = 16383;
      if (yr < -16384) yr = -16384;
      r.year = yr[YEAR_W-1:0];
      r.month = mo[MON_W-1:0];
      r.mday = dy[DAYO_W-1:0];
    end
    return r;
  endfunction

  function automatic conv_request_t noise_request();
    conv_request_t rq;
    rq.cmd = 1'($urandom_range(0, 1));
    rq.year = YEAR_W'($urandom);
    rq.month = MON_W'($urandom);
    rq.mday = DAYI_W'($urandom);
    rq.jdn = JDN_W'($urandom);
    return rq;
  endfunction

  function automatic conv_request_t date_item(input int y, input int m, input int d);
    conv_request_t rq;
    rq = noise_request();
    rq.cmd = CMD_TO_DAY;
    rq.year = YEAR_W'(y);
    rq.month = MON_W'(m);
    rq.mday = DAYI_W'(d);
    return rq;
  endfunction

  function automatic conv_request_t day_item(input int n);
    conv_request_t rq;
    rq = noise_request();
    rq.cmd = CMD_TO_DATE;
    rq.jdn = JDN_W'(n);
    return rq;
  endfunction

  function automatic conv_request_t random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return date_item($urandom_range(0, 14712) - 4713, $urandom_range(1, 12),
                       $urandom_range(1, 31));
    end else if (pick < 55) begin
      return date_item($urandom, $urandom, $urandom);
    end else if (pick < 90) begin
      return day_item($urandom_range(0, 5373484));
    end
    return day_item($urandom);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MAX) $display("%t  %s", $realtime, msg);
  endtask

  task automatic offer_request(input conv_request_t rq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= rq.cmd;
    year_in <= rq.year;
    month_in <= rq.month;
    day_in <= rq.mday;
    day_number_in <= rq.jdn;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    answers_due.push_back(convert_calendar(rq, cutover_day));
    if (rq.cmd == CMD_TO_DATE) begin
      day_numbers_sent++;
    end else begin
      dates_sent++;
      if (rq.mday > 31 || rq.month > 12) bad_dates_sent++;
    end
    @(negedge clk);
  endtask

  task automatic wait_for_answers();
    item_valid <= 1'b0;
    wait (answers_due.size() == 0);
    @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_START;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_cutover(input logic [JDN_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    wait_for_answers();
    apb_transfer(1'b1, PDATA_W'(value), rd);
    cutover_day = value;
    apb_transfer(1'b0, '0, rd);
    if (rd[JDN_W-1:0] !== value)
      flag_error($sformatf("cutover readback: expected %0d, got %0d", value, rd[JDN_W-1:0]));
    settings_used++;
  endtask

  // Checks the reset value of the cutover register.
  task automatic test_register_reset();
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd[JDN_W-1:0] !== START_RESET)
      flag_error($sformatf("cutover after reset: expected %0d, got %0d", START_RESET,
                           rd[JDN_W-1:0]));
  endtask

  task automatic test_directed();
    offer_request(date_item(-4713, 1, 1));
    offer_request(date_item(9999, 12, 31));
    offer_request(date_item(1582, 10, 4));
    offer_request(date_item(1582, 10, 15));
    offer_request(date_item(1582, 10, 10));
    offer_request(date_item(2000, 2, 29));
    offer_request(date_item(-16384, 0, 0));
    offer_request(date_item(16383, 12, 31));
    offer_request(date_item(0, 3, 1));
    offer_request(date_item(2024, 0, 15));
    offer_request(date_item(2024, 3, 0));
    offer_request(date_item(2024, 13, 1));
    offer_request(date_item(2024, 15, 63));
    offer_request(date_item(2024, 12, 32));
    offer_request(date_item(2024, 0, 31));
    offer_request(day_item(0));
    offer_request(day_item(2299160));
    offer_request(day_item(2299161));
    offer_request(day_item(2451545));
    offer_request(day_item(5373484));
    offer_request(day_item(8388607));
  endtask

  task automatic test_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i % 100 == 50) wait_for_answers();
      offer_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  // Hit both sides of each cutover in both directions, then random traffic.
  task automatic test_cutover_sweep();
    logic [JDN_W-1:0] settings[5];
    conv_answer_t     edge_date;
    settings = '{23'd0, 23'd5373484, 23'h7FFFFF, JDN_W'($urandom_range(0, 5373484)),
                 START_RESET};
    foreach (settings[k]) begin
      program_cutover(settings[k]);
      offer_request(day_item(settings[k] - 1));
      offer_request(day_item(int'(settings[k])));
      offer_request(day_item(settings[k] + 1));
      edge_date = convert_calendar(day_item(int'(settings[k])), settings[k]);
      offer_request(date_item(int'(edge_date.year), int'(edge_date.month),
                              int'(edge_date.mday)));
      offer_request(date_item(int'(edge_date.year), int'(edge_date.month),
                              int'(edge_date.mday) - 1));
      offer_request(date_item(int'(edge_date.year), int'(edge_date.month),
                              int'(edge_date.mday) + 1));
      test_random_items(40);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    conv_answer_t got, want;
    if (!rst && result_valid && !result_stall) begin
      got = {day_number_out, year_out, month_out, day_out, bad_date};
      stall_left = no_idle ? 0 : $urandom_range(0, 11);
      results_seen++;
      if (answers_due.size() == 0) begin
        flag_error($sformatf("unexpected result: jdn %0d date %0d-%0d-%0d bad %0b",
                             got.jdn, got.year, got.month, got.mday, got.bad_date));
      end else begin
        want = answers_due.pop_front();
        if (got !== want)
          flag_error($sformatf({"result mismatch: expected jdn %0d date %0d-%0d-%0d bad %0b,",
                                " got jdn %0d date %0d-%0d-%0d bad %0b"},
                               want.jdn, want.year, want.month, want.mday, want.bad_date,
                               got.jdn, got.year, got.month, got.mday, got.bad_date));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               answers_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_reset();
    test_directed();
    test_random_items(200);
    test_cutover_sweep();
    wait_for_answers();
    repeat (16) @(posedge clk);
    $display("Sent %0d dates (%0d malformed) and %0d day numbers over %0d cutover settings;",
             dates_sent, bad_dates_sent, day_numbers_sent, settings_used);
    $display("checked %0d results, %0d errors", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/jdnc_pkg.sv
rtl/core/jdnc_core.sv
rtl/core/julian_day_number_conversion_top.sv
tb/julian_day_number_conversion_top_test.sv
